// File: hdl/bsfr_pkg.sv
// shared types and constants for the byte-stuffed frame receiver
`default_nettype none
package bsfr_pkg;

  localparam int BYTE_W      = 8;
  localparam int CNT_W       = 10;
  localparam int KIND_W      = 2;
  localparam int REG_IDX_W   = 2;
  localparam int MAX_RAW_DEF = 512;

  // depth of the queue between front and back, a power of two
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [BYTE_W-1:0] ESC_XOR = 8'h20;

  localparam logic [BYTE_W-1:0] FLAG_RESET = 8'd126;
  localparam logic [BYTE_W-1:0] END_RESET  = 8'd127;
  localparam logic [BYTE_W-1:0] ESC_RESET  = 8'd125;

  // configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_FLAG = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_END  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_ESC  = 2'd2;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_DATA = 2'd0;
  localparam logic [KIND_W-1:0] KIND_END  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_OVF  = 2'd2;

  // queued operations for the back end
  localparam logic [1:0] OP_DATA    = 2'd0;
  localparam logic [1:0] OP_END     = 2'd1;
  localparam logic [1:0] OP_END_ESC = 2'd2;
  localparam logic [1:0] OP_OVF     = 2'd3;

  typedef struct packed {
    logic [1:0]        op;
    logic [BYTE_W-1:0] value;
  } bsfr_entry_t;

endpackage
`default_nettype wire

// File: hdl/byte_stuffed_frame_receiver_core.sv
// top level of the byte-stuffed frame receiver
// Usage:
//   Line bytes enter on in_valid/in_byte; an item is taken at a clock edge
//   with in_valid high and in_stall low. Results leave on out_valid with
//   out_byte, out_kind (data, end of frame, overflow error) and out_last,
//   taken at an edge with out_valid high and out_stall low.
//   cfg_wr_en/cfg_index/cfg_wdata write the flag, end and escape byte values
//   while the block is idle; index 3 is ignored.
// Timing:
//   one item per cycle while in_stall is low; the front end classifies and
//   updates frame state in the accept cycle and queues at most one operation,
//   the back end turns it into results from a 4-entry queue. Each result
//   passes through the queue and then the output register. An end byte with a
//   pending escape yields two results: the escape byte as data, then the end.
// Reset and stall:
//   synchronous reset (rst_n low) restores default byte values, leaves the
//   frame and empties the queue. A stalled output holds its result; once the
//   queue fills, in_stall rises until the receiver takes results again.
`default_nettype none
module byte_stuffed_frame_receiver_core #(
  parameter int MAX_RAW_BYTES = bsfr_pkg::MAX_RAW_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_wr_en,
  input  wire logic [bsfr_pkg::REG_IDX_W-1:0] cfg_index,
  input  wire logic [bsfr_pkg::BYTE_W-1:0]    cfg_wdata,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [bsfr_pkg::BYTE_W-1:0]    in_byte,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [bsfr_pkg::BYTE_W-1:0]         out_byte,
  output logic [bsfr_pkg::KIND_W-1:0]         out_kind,
  output logic                                out_last
);

  logic                  push, pop, q_full, q_empty;
  bsfr_pkg::bsfr_entry_t push_entry, head;

  bsfr_front #(
    .MAX_RAW_BYTES(MAX_RAW_BYTES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_byte    (in_byte),
    .in_stall   (in_stall),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  bsfr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .full       (q_full),
    .empty      (q_empty)
  );

  bsfr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .empty     (q_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_kind  (out_kind),
    .out_last  (out_last)
  );

endmodule
`default_nettype wire

// File: hdl/bsfr_front.sv
// front end: configuration registers, frame state and byte classification
`default_nettype none
module bsfr_front #(
  parameter int MAX_RAW_BYTES = bsfr_pkg::MAX_RAW_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_wr_en,
  input  wire logic [bsfr_pkg::REG_IDX_W-1:0] cfg_index,
  input  wire logic [bsfr_pkg::BYTE_W-1:0]    cfg_wdata,
  input  wire logic                           in_valid,
  input  wire logic [bsfr_pkg::BYTE_W-1:0]    in_byte,
  output logic                                in_stall,
  input  wire logic                           q_full,
  output logic                                push,
  output bsfr_pkg::bsfr_entry_t               push_entry
);

  localparam logic [bsfr_pkg::CNT_W-1:0] MAX_CNT = bsfr_pkg::CNT_W'(MAX_RAW_BYTES);

  logic [bsfr_pkg::BYTE_W-1:0] flag_r, end_r, esc_val_r;
  logic                        in_frame_r, in_frame_nxt;
  logic                        esc_pend_r, esc_pend_nxt;
  logic [bsfr_pkg::CNT_W-1:0]  raw_count_r, raw_count_nxt;
  logic                        accept;
  logic                        emit;
  bsfr_pkg::bsfr_entry_t       entry;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r    <= bsfr_pkg::FLAG_RESET;
      end_r     <= bsfr_pkg::END_RESET;
      esc_val_r <= bsfr_pkg::ESC_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        bsfr_pkg::REG_FLAG: flag_r    <= cfg_wdata;
        bsfr_pkg::REG_END:  end_r     <= cfg_wdata;
        bsfr_pkg::REG_ESC:  esc_val_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // priority: flag, then end, then everything else
  always_comb begin
    in_frame_nxt  = in_frame_r;
    esc_pend_nxt  = esc_pend_r;
    raw_count_nxt = raw_count_r;
    emit          = 1'b0;
    entry.op      = bsfr_pkg::OP_DATA;
    entry.value   = in_byte;
    if (in_byte == flag_r) begin
      in_frame_nxt  = 1'b1;
      esc_pend_nxt  = 1'b0;
      raw_count_nxt = bsfr_pkg::CNT_W'(1);
      emit          = 1'b1;
    end else if (in_byte == end_r) begin
      if (in_frame_r) begin
        emit          = 1'b1;
        entry.op      = esc_pend_r ? bsfr_pkg::OP_END_ESC : bsfr_pkg::OP_END;
        entry.value   = esc_val_r;
        in_frame_nxt  = 1'b0;
        esc_pend_nxt  = 1'b0;
        raw_count_nxt = '0;
      end
    end else if (in_frame_r) begin
      if (raw_count_r >= MAX_CNT) begin
        emit          = 1'b1;
        entry.op      = bsfr_pkg::OP_OVF;
        in_frame_nxt  = 1'b0;
        esc_pend_nxt  = 1'b0;
        raw_count_nxt = '0;
      end else begin
        raw_count_nxt = raw_count_r + 1'b1;
        if (esc_pend_r) begin
          esc_pend_nxt = 1'b0;
          emit         = 1'b1;
          entry.value  = in_byte ^ bsfr_pkg::ESC_XOR;
        end else if (in_byte == esc_val_r) begin
          esc_pend_nxt = 1'b1;
        end else begin
          emit = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r  <= 1'b0;
      esc_pend_r  <= 1'b0;
      raw_count_r <= '0;
    end else if (accept) begin
      in_frame_r  <= in_frame_nxt;
      esc_pend_r  <= esc_pend_nxt;
      raw_count_r <= raw_count_nxt;
    end
  end

  assign push       = accept && emit;
  assign push_entry = entry;

  a_esc_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    esc_pend_r |-> in_frame_r) else $error("escape pending outside a frame");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    raw_count_r <= MAX_CNT) else $error("raw count beyond limit");

  a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
    !in_frame_r |-> (raw_count_r == '0)) else $error("count held outside a frame");

endmodule
`default_nettype wire

// File: hdl/bsfr_queue.sv
// short queue of classified operations between front and back
`default_nettype none
module bsfr_queue (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire bsfr_pkg::bsfr_entry_t push_entry,
  input  wire logic                  pop,
  output bsfr_pkg::bsfr_entry_t      head,
  output logic                       full,
  output logic                       empty
);

  localparam logic [bsfr_pkg::QCNT_W-1:0] DEPTH_CNT =
    bsfr_pkg::QCNT_W'(bsfr_pkg::QUEUE_DEPTH);

  bsfr_pkg::bsfr_entry_t            mem_r [bsfr_pkg::QUEUE_DEPTH];
  logic [bsfr_pkg::QPTR_W-1:0]      wr_ptr_r, rd_ptr_r;
  logic [bsfr_pkg::QCNT_W-1:0]      count_r, count_nxt;

  assign full  = (count_r == DEPTH_CNT);
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full)) else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty)) else $error("pop from an empty queue");

  a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0 && count_r != DEPTH_CNT) |-> (wr_ptr_r != rd_ptr_r))
    else $error("pointers disagree with fill count");

endmodule
`default_nettype wire

// File: hdl/bsfr_back.sv
// back end: expands queued operations into results behind an output register
`default_nettype none
module bsfr_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire bsfr_pkg::bsfr_entry_t       head,
  input  wire logic                        empty,
  output logic                             pop,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [bsfr_pkg::BYTE_W-1:0]      out_byte,
  output logic [bsfr_pkg::KIND_W-1:0]      out_kind,
  output logic                             out_last
);

  logic                          out_valid_r;
  logic [bsfr_pkg::BYTE_W-1:0]   out_byte_r;
  logic [bsfr_pkg::KIND_W-1:0]   out_kind_r;
  logic                          out_last_r;
  logic                          phase_r;   // end result still owed after the raw escape
  logic                          load_ok;

  assign load_ok = !out_valid_r || !out_stall;
  assign pop     = load_ok && !phase_r && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
    end else if (load_ok) begin
      if (phase_r) begin
        out_valid_r <= 1'b1;
        phase_r     <= 1'b0;
      end else if (!empty) begin
        out_valid_r <= 1'b1;
        phase_r     <= (head.op == bsfr_pkg::OP_END_ESC);
      end else begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok) begin
      if (phase_r) begin
        out_byte_r <= '0;
        out_kind_r <= bsfr_pkg::KIND_END;
        out_last_r <= 1'b1;
      end else begin
        case (head.op)
          bsfr_pkg::OP_DATA: begin
            out_byte_r <= head.value;
            out_kind_r <= bsfr_pkg::KIND_DATA;
            out_last_r <= 1'b1;
          end
          bsfr_pkg::OP_END: begin
            out_byte_r <= '0;
            out_kind_r <= bsfr_pkg::KIND_END;
            out_last_r <= 1'b1;
          end
          bsfr_pkg::OP_END_ESC: begin
            out_byte_r <= head.value;
            out_kind_r <= bsfr_pkg::KIND_DATA;
            out_last_r <= 1'b0;
          end
          default: begin
            out_byte_r <= '0;
            out_kind_r <= bsfr_pkg::KIND_OVF;
            out_last_r <= 1'b1;
          end
        endcase
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_kind  = out_kind_r;
  assign out_last  = out_last_r;

  a_phase_shape: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> (out_valid_r && !out_last_r && out_kind_r == bsfr_pkg::KIND_DATA))
    else $error("owed end result without its leading data item");

  a_non_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r != bsfr_pkg::KIND_DATA) |-> (out_byte_r == '0 && out_last_r))
    else $error("end or error item with payload or without last");

  a_phase_follow: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r && !out_stall) |=> (out_valid_r && out_kind_r == bsfr_pkg::KIND_END))
    else $error("end item did not follow the raw escape");

endmodule
`default_nettype wire
